@@ rtl/ltc_pkg.sv @@
// Shared types and constants for the language tag checker.
package ltc_pkg;

    localparam int LEN_W = 4;

    localparam logic [LEN_W-1:0] LEN_SAT         = 4'd15;
    localparam logic [LEN_W-1:0] MAX_PART_LEN    = 4'd8;
    localparam logic [LEN_W-1:0] MIN_PRIMARY_LEN = 4'd2;
    localparam logic [LEN_W-1:0] MIN_EXT_LEN     = 4'd2;

    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef struct packed {
        logic [LEN_W-1:0] part_length;
        logic             in_primary;
        logic             awaiting_extension;
        logic             private_mode;
        logic             private_seen;
        logic             singleton_is_x;
        logic             tag_failed;
    } scan_state_t;

    localparam scan_state_t STATE_RESET = '{
        part_length:        '0,
        in_primary:         1'b1,
        awaiting_extension: 1'b0,
        private_mode:       1'b0,
        private_seen:       1'b0,
        singleton_is_x:     1'b0,
        tag_failed:         1'b0
    };

endpackage

@@ rtl/language_tag_checker.sv @@
// Language tag well-formedness checker: one input register stage and one result register.
// Path: a final beat is held in the input register stage, then its tag_ok is written to the
// result register once that register is free.
// Throughput: one tag byte per cycle; the input stalls only while a final beat waits
// for the result register, which is held by a stalled consumer.
// Reset: asynchronous, active low; the scan state returns to its start values and
// both pipeline stages are emptied. The scan state also returns to start after each tag.
module language_tag_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] tag_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tag_ok
);

    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;
    logic                  s1_final_reg;
    ltc_pkg::scan_state_t  state_reg;
    ltc_pkg::scan_state_t  state_next;
    logic                  out_valid_reg;
    logic                  tag_ok_reg;
    logic                  tag_ok_next;
    logic                  s1_advance;

    // Applies the end-of-subtag rules to a scan state.
    function automatic ltc_pkg::scan_state_t close_part(input ltc_pkg::scan_state_t s);
        ltc_pkg::scan_state_t r;
        logic [ltc_pkg::LEN_W-1:0] n;
        r = s;
        n = s.part_length;
        if (s.in_primary) begin
            if ((n < ltc_pkg::MIN_PRIMARY_LEN) || (n > ltc_pkg::MAX_PART_LEN)) begin
                r.tag_failed = 1'b1;
            end
            r.in_primary = 1'b0;
        end else if ((n == '0) || (n > ltc_pkg::MAX_PART_LEN)) begin
            r.tag_failed = 1'b1;
        end else if (s.private_mode) begin
            r.private_seen = 1'b1;
        end else if (s.awaiting_extension) begin
            if (n < ltc_pkg::MIN_EXT_LEN) begin
                r.tag_failed = 1'b1;
            end
            r.awaiting_extension = 1'b0;
        end else if (n == ltc_pkg::LEN_W'(1)) begin
            if (s.singleton_is_x) begin
                r.private_mode = 1'b1;
            end else begin
                r.awaiting_extension = 1'b1;
            end
        end
        r.part_length    = '0;
        r.singleton_is_x = 1'b0;
        return r;
    endfunction

    // A non-final beat never produces a result, so only a final beat waits on the output.
    assign s1_advance = s1_valid_reg && (!s1_final_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        ltc_pkg::scan_state_t s1;
        ltc_pkg::scan_state_t s2;
        logic is_letter;
        logic is_digit;
        is_letter = ((s1_byte_reg >= ltc_pkg::CH_UPPER_A) && (s1_byte_reg <= ltc_pkg::CH_UPPER_Z))
                 || ((s1_byte_reg >= ltc_pkg::CH_LOWER_A) && (s1_byte_reg <= ltc_pkg::CH_LOWER_Z));
        is_digit  = (s1_byte_reg >= ltc_pkg::CH_DIGIT_0) && (s1_byte_reg <= ltc_pkg::CH_DIGIT_9);
        if (s1_byte_reg == ltc_pkg::CH_HYPHEN) begin
            s1 = close_part(state_reg);
        end else begin
            s1 = state_reg;
            if (!(is_letter || (!state_reg.in_primary && is_digit))) begin
                s1.tag_failed = 1'b1;
            end
            if (state_reg.part_length == '0) begin
                s1.singleton_is_x = (s1_byte_reg == ltc_pkg::CH_LOWER_X)
                                 || (s1_byte_reg == ltc_pkg::CH_UPPER_X);
            end
            if (state_reg.part_length != ltc_pkg::LEN_SAT) begin
                s1.part_length = state_reg.part_length + ltc_pkg::LEN_W'(1);
            end
        end
        // The final beat closes the last subtag, even right after a hyphen.
        s2 = close_part(s1);
        tag_ok_next = !(s2.tag_failed || s2.awaiting_extension
                        || (s2.private_mode && !s2.private_seen));
        if (s1_final_reg) begin
            state_next = ltc_pkg::STATE_RESET;
        end else begin
            state_next = s1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= ltc_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance) begin
                state_reg <= state_next;
            end
            if (s1_advance && s1_final_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_byte_reg  <= tag_byte;
            s1_final_reg <= final_byte;
        end
        if (s1_advance && s1_final_reg) begin
            tag_ok_reg <= tag_ok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tag_ok    = tag_ok_reg;

    a_reset_after_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_final_reg) |=> (state_reg == ltc_pkg::STATE_RESET))
        else $error("scan state not restarted after final beat");

    a_primary_rises_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.in_primary) |-> $past(s1_advance && s1_final_reg))
        else $error("primary subtag restarted inside a tag");

    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_advance && s1_final_reg))
        else $error("result produced without a final beat");

    a_private_flags: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.private_seen |-> (state_reg.private_mode && !state_reg.awaiting_extension))
        else $error("inconsistent private use flags");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_final_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

endmodule
